/* sv/rcf_pkg.sv */
// rcf_pkg: shared constants, codes, state and mode types, and the tap weighting
// for the 3x3 RGB convolution filter.
// No dependencies; compiled before every other file.
package rcf_pkg;

   // field widths
   localparam int PIX_W   = 8;
   localparam int COORD_W = 9;
   localparam int CFG_W   = 10;
   localparam int MODE_W  = 2;
   localparam int IDX_W   = 3;
   localparam int ACC_W   = 13;

   // default store geometry
   localparam int DEF_MAX_COLS = 512;
   localparam int DEF_MAX_ROWS = 512;

   // register reset values
   localparam int RST_IMAGE_W   = 512;
   localparam int RST_IMAGE_H   = 512;
   localparam int RST_SEL_LEFT  = 0;
   localparam int RST_SEL_TOP   = 0;
   localparam int RST_SEL_RIGHT = 512;
   localparam int RST_SEL_BOT   = 512;

   // box blur scaling: q = (1111*T + 5000) / 10000, by reciprocal 2^36 / 10000
   localparam int BOX_WEIGHT  = 1111;
   localparam int ROUND_BIAS  = 5000;
   localparam int BOX_RECIP   = 6871948;
   localparam int RECIP_SHIFT = 36;
   localparam int SUM_W       = 22;
   localparam int RECIP_W     = 23;
   localparam int PROD_W      = SUM_W + RECIP_W;

   // gaussian: (625*G + 5000) / 10000 == (G + 8) >> 4
   localparam int GAUSS_BIAS  = 8;
   localparam int GAUSS_SHIFT = 4;

   typedef logic signed [ACC_W-1:0] acc_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_EDGE,
      MODE_SHARPEN,
      MODE_BOX,
      MODE_GAUSS
   } filter_mode_type;

   typedef enum logic [IDX_W-1:0] {
      CSR_FILTER_MODE = 3'd0,
      CSR_IMAGE_W     = 3'd1,
      CSR_IMAGE_H     = 3'd2,
      CSR_SEL_LEFT    = 3'd3,
      CSR_SEL_TOP     = 3'd4,
      CSR_SEL_RIGHT   = 3'd5,
      CSR_SEL_BOT     = 3'd6
   } csr_index_type;

   typedef enum logic {
      REQ_WRITE = 1'b0,
      REQ_READ  = 1'b1
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CENTER,
      ST_TAP,
      ST_DRAIN,
      ST_SCALE_A,
      ST_SCALE_B,
      ST_OUT
   } fsm_state_type;

   // one sample times its kernel weight, in units that drop the common scale
   function automatic acc_type tap_term(filter_mode_type mode, logic [1:0] dr,
                                        logic [1:0] dc, logic [PIX_W-1:0] s);
      acc_type sv;
      logic    centre;
      logic    on_cross;
      sv       = signed'(ACC_W'(s));
      centre   = (dr == 2'd1) && (dc == 2'd1);
      on_cross = (dr == 2'd1) != (dc == 2'd1);
      case (mode)
         MODE_EDGE:    tap_term = centre ? (sv <<< 3) : -sv;
         MODE_SHARPEN: tap_term = centre ? ((sv <<< 2) + sv) : (on_cross ? -sv : '0);
         MODE_BOX:     tap_term = sv;
         MODE_GAUSS:   tap_term = centre ? (sv <<< 2) : (on_cross ? (sv <<< 1) : sv);
         default:      tap_term = '0;
      endcase
   endfunction

endpackage

/* sv/rcf_chan_if.sv */
// rcf_chan_if: valid/ready channel interfaces for requests and results.
// Depends on rcf_pkg for field widths.
interface rcf_req_if;
   import rcf_pkg::*;
   logic               valid;
   logic               ready;
   logic [0:0]         req_type;
   logic [COORD_W-1:0] row;
   logic [COORD_W-1:0] col;
   logic [PIX_W-1:0]   red_in;
   logic [PIX_W-1:0]   green_in;
   logic [PIX_W-1:0]   blue_in;

   modport source (output valid, req_type, row, col, red_in, green_in, blue_in,
                   input ready);
   modport sink   (input valid, req_type, row, col, red_in, green_in, blue_in,
                   output ready);
endinterface

interface rcf_rsp_if;
   import rcf_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] red_out;
   logic [PIX_W-1:0] green_out;
   logic [PIX_W-1:0] blue_out;
   logic [0:0]       filtered;

   modport source (output valid, red_out, green_out, blue_out, filtered,
                   input ready);
   modport sink   (input valid, red_out, green_out, blue_out, filtered,
                   output ready);
endinterface

/* sv/rgb_conv3x3_filter_top.sv */
// rgb_conv3x3_filter_top: pixel store with a 3x3 RGB convolution on read.
// Depends on rcf_pkg and the channel interfaces in rcf_chan_if.sv.
//
//   channel    direction  handshake        carries
//   req_chan   in         valid/ready      req_type, row, col, red/green/blue_in
//   rsp_chan   out        valid/ready      red/green/blue_out, filtered
//   csr_*      in         csr_we only      csr_index, csr_wdata (no read-back)
//
// A write request is taken in the idle state and returns nothing. A read that is
// not filtered returns its centre pixel (zero if out of range) via the output state;
// a filtered read makes nine neighbour reads through the single pixel memory port,
// one per cycle, then one drain step and a scale A and scale B step per colour
// channel through the shared scaling multiplier. Reset is synchronous; the pixel
// memory is not cleared. The result register holds while rsp_chan stalls; a new
// request is taken meanwhile; a read that finishes waits in its last state for the slot.
module rgb_conv3x3_filter_top #(
   parameter int MAX_COLS = rcf_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = rcf_pkg::DEF_MAX_ROWS
) (
   input  logic                      clock,
   input  logic                      reset,
   rcf_req_if.sink                   req_chan,
   rcf_rsp_if.source                 rsp_chan,
   input  logic                      csr_we,
   input  logic [rcf_pkg::IDX_W-1:0] csr_index,
   input  logic [rcf_pkg::CFG_W-1:0] csr_wdata
);
   import rcf_pkg::*;

   localparam int DEPTH   = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int DIM_MAX = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
   localparam int CMP_W   = (($clog2(DIM_MAX + 1) > CFG_W) ? $clog2(DIM_MAX + 1) : CFG_W) + 1;
   localparam int NB_W    = COORD_W + 1;
   localparam int WORD_W  = 3 * PIX_W;

   // configuration registers
   filter_mode_type  mode_ff;
   logic [CFG_W-1:0] width_ff, height_ff;
   logic [CFG_W-1:0] sel_left_ff, sel_top_ff, sel_right_ff, sel_bot_ff;

   // sequencer
   fsm_state_type state_ff, state_in;

   // request context and tap walk
   logic [COORD_W-1:0] row_ff, col_ff;
   logic [1:0]         dr_ff, dc_ff;
   logic [1:0]         tdr_ff, tdc_ff;
   logic               q_vld_ff;
   logic [1:0]         chan_ff;

   // accumulators and scaling
   acc_type            acc_ff [3];
   logic [SUM_W-1:0]   y_ff;
   logic [PIX_W-1:0]   res_ff [3];
   logic               res_filt_ff;

   // result register
   logic               rsp_valid_ff;
   logic [PIX_W-1:0]   rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic               rsp_filt_ff;

   // pixel memory
   logic [WORD_W-1:0]  mem [DEPTH];
   logic [WORD_W-1:0]  mem_q_ff;
   logic [ADDR_W-1:0]  mem_addr;
   logic               mem_we;

   // combinational control
   logic               req_fire;
   logic               is_read;
   logic               in_range;
   logic               apply;
   logic               load_rsp;
   logic               tap_last;
   logic [CMP_W-1:0]   r_c, c_c, r1_c, c1_c;
   logic [NB_W-1:0]    tap_row, tap_col;
   logic [ADDR_W-1:0]  req_addr, tap_addr;
   acc_type            cur_acc;
   logic [PROD_W-1:0]  prod;
   logic [ACC_W-1:0]   gauss_sum;
   logic [PIX_W-1:0]   scaled;

   function automatic logic [ADDR_W-1:0] pix_addr(logic [NB_W-1:0] r, logic [NB_W-1:0] c);
      pix_addr = ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c));
   endfunction

   // request decode and window test
   assign req_fire = req_chan.valid && req_chan.ready;
   assign is_read  = req_kind_type'(req_chan.req_type) == REQ_READ;
   assign r_c      = CMP_W'(req_chan.row);
   assign c_c      = CMP_W'(req_chan.col);
   assign r1_c     = r_c + CMP_W'(1);
   assign c1_c     = c_c + CMP_W'(1);
   assign in_range = (r_c < CMP_W'(MAX_ROWS)) && (c_c < CMP_W'(MAX_COLS));
   assign apply    = (r_c != '0) && (c_c != '0)
                  && (r1_c < CMP_W'(height_ff)) && (c1_c < CMP_W'(width_ff))
                  && (r1_c < CMP_W'(MAX_ROWS)) && (c1_c < CMP_W'(MAX_COLS))
                  && (r_c >= CMP_W'(sel_top_ff)) && (r_c < CMP_W'(sel_bot_ff))
                  && (c_c >= CMP_W'(sel_left_ff)) && (c_c < CMP_W'(sel_right_ff));

   // addresses
   assign req_addr = pix_addr(NB_W'(req_chan.row), NB_W'(req_chan.col));
   assign tap_row  = NB_W'(row_ff) + NB_W'(dr_ff) - NB_W'(1);
   assign tap_col  = NB_W'(col_ff) + NB_W'(dc_ff) - NB_W'(1);
   assign tap_addr = pix_addr(tap_row, tap_col);
   assign tap_last = (dr_ff == 2'd2) && (dc_ff == 2'd2);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_EDGE;
         width_ff     <= CFG_W'(RST_IMAGE_W);
         height_ff    <= CFG_W'(RST_IMAGE_H);
         sel_left_ff  <= CFG_W'(RST_SEL_LEFT);
         sel_top_ff   <= CFG_W'(RST_SEL_TOP);
         sel_right_ff <= CFG_W'(RST_SEL_RIGHT);
         sel_bot_ff   <= CFG_W'(RST_SEL_BOT);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_FILTER_MODE: mode_ff      <= filter_mode_type'(csr_wdata[MODE_W-1:0]);
            CSR_IMAGE_W:     width_ff     <= csr_wdata;
            CSR_IMAGE_H:     height_ff    <= csr_wdata;
            CSR_SEL_LEFT:    sel_left_ff  <= csr_wdata;
            CSR_SEL_TOP:     sel_top_ff   <= csr_wdata;
            CSR_SEL_RIGHT:   sel_right_ff <= csr_wdata;
            CSR_SEL_BOT:     sel_bot_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && is_read) begin
               if (!in_range) state_in = ST_OUT;
               else if (apply) state_in = ST_TAP;
               else state_in = ST_CENTER;
            end
         end
         ST_CENTER:  state_in = ST_OUT;
         ST_TAP:     if (tap_last) state_in = ST_DRAIN;
         ST_DRAIN:   state_in = ST_SCALE_A;
         ST_SCALE_A: state_in = ST_SCALE_B;
         ST_SCALE_B: state_in = (chan_ff == 2'd2) ? ST_OUT : ST_SCALE_A;
         ST_OUT:     if (!rsp_valid_ff || rsp_chan.ready) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_chan.ready = 1'b0;
      mem_addr       = req_addr;
      mem_we         = 1'b0;
      load_rsp       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            mem_we         = req_chan.valid && !is_read && in_range;
         end
         ST_TAP:  mem_addr = tap_addr;
         ST_OUT:  load_rsp = !rsp_valid_ff || rsp_chan.ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         q_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         q_vld_ff <= state_ff == ST_TAP;
      end
   end

   // pixel memory, single port with registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= {req_chan.red_in, req_chan.green_in, req_chan.blue_in};
      end
      mem_q_ff <= mem[mem_addr];
   end

   // shared scaling unit, one colour channel per pass
   assign cur_acc   = acc_ff[chan_ff];
   assign prod      = PROD_W'(y_ff) * PROD_W'(BOX_RECIP);
   assign gauss_sum = $unsigned(cur_acc) + ACC_W'(GAUSS_BIAS);

   always_comb begin
      case (mode_ff) inside
         MODE_EDGE, MODE_SHARPEN: begin
            if (cur_acc[ACC_W-1] || cur_acc == '0) scaled = '0;
            else if (cur_acc[ACC_W-2:PIX_W] != '0) scaled = '1;
            else scaled = cur_acc[PIX_W-1:0];
         end
         MODE_BOX:   scaled = prod[RECIP_SHIFT +: PIX_W];
         MODE_GAUSS: scaled = gauss_sum[GAUSS_SHIFT +: PIX_W];
         default:    scaled = '0;
      endcase
   end

   // datapath: request context, tap walk, accumulation, scaling
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_fire && is_read) begin
         row_ff  <= req_chan.row;
         col_ff  <= req_chan.col;
         dr_ff   <= '0;
         dc_ff   <= '0;
         chan_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            acc_ff[i] <= '0;
            res_ff[i] <= '0;
         end
         res_filt_ff <= 1'b0;
      end

      // step through the 3x3 window, row by row
      if (state_ff == ST_TAP) begin
         tdr_ff <= dr_ff;
         tdc_ff <= dc_ff;
         if (dc_ff == 2'd2) begin
            dc_ff <= '0;
            dr_ff <= dr_ff + 2'd1;
         end else begin
            dc_ff <= dc_ff + 2'd1;
         end
      end

      // add the neighbour that came back from memory
      if (q_vld_ff) begin
         for (int i = 0; i < 3; i++) begin
            acc_ff[i] <= acc_ff[i]
                       + tap_term(mode_ff, tdr_ff, tdc_ff, mem_q_ff[(2-i)*PIX_W +: PIX_W]);
         end
      end

      // pass-through pixel
      if (state_ff == ST_CENTER) begin
         for (int i = 0; i < 3; i++) begin
            res_ff[i] <= mem_q_ff[(2-i)*PIX_W +: PIX_W];
         end
         res_filt_ff <= 1'b0;
      end

      if (state_ff == ST_SCALE_A) begin
         y_ff <= SUM_W'(SUM_W'($unsigned(cur_acc)) * SUM_W'(BOX_WEIGHT)) + SUM_W'(ROUND_BIAS);
      end

      if (state_ff == ST_SCALE_B) begin
         res_ff[chan_ff] <= scaled;
         res_filt_ff     <= 1'b1;
         chan_ff         <= chan_ff + 2'd1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_red_ff   <= res_ff[0];
         rsp_green_ff <= res_ff[1];
         rsp_blue_ff  <= res_ff[2];
         rsp_filt_ff  <= res_filt_ff;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.red_out   = rsp_red_ff;
   assign rsp_chan.green_out = rsp_green_ff;
   assign rsp_chan.blue_out  = rsp_blue_ff;
   assign rsp_chan.filtered  = rsp_filt_ff;

endmodule

/* sv/rcf_checker.sv */
// rcf_checker: port-level checks on the filter's request and result channels,
// bound to rgb_conv3x3_filter_top. Depends on rcf_pkg.
module rcf_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic [0:0]                req_type,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [rcf_pkg::PIX_W-1:0] rsp_red,
   input logic [rcf_pkg::PIX_W-1:0] rsp_green,
   input logic [rcf_pkg::PIX_W-1:0] rsp_blue,
   input logic [0:0]                rsp_filtered
);
   import rcf_pkg::*;

   logic req_fire;
   assign req_fire = req_valid && req_ready;

   // a read keeps the block busy: ready drops in the cycle after it is taken
   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_type == REQ_READ |=> !req_ready)
      else $error("request port ready right after a read request");

   // a write finishes in the cycle it is taken
   a_write_quick: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_type == REQ_WRITE |=> req_ready)
      else $error("request port not ready after a write request");

   // a new result only appears while the block is busy with a read
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without a read in flight");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid
         && $stable({rsp_red, rsp_green, rsp_blue, rsp_filtered}))
      else $error("result changed while stalled");

endmodule

bind rgb_conv3x3_filter_top rcf_checker u_rcf_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .req_type     (req_chan.req_type),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_red      (rsp_chan.red_out),
   .rsp_green    (rsp_chan.green_out),
   .rsp_blue     (rsp_chan.blue_out),
   .rsp_filtered (rsp_chan.filtered)
);

/* dv/tb.sv */
`timescale 1ns / 100ps
// tb: self-checking bench for rgb_conv3x3_filter_top, pixel writes and filtered reads
// checked against a local 3x3 convolution predictor. Needs rcf_pkg, the channel
// interfaces in rcf_chan_if.sv and the filter top level.
module tb;
   import rcf_pkg::*;

   localparam int unsigned STORE_COLS  = DEF_MAX_COLS;
   localparam int unsigned STORE_ROWS  = DEF_MAX_ROWS;
   localparam int unsigned STORE_DEPTH = STORE_COLS * STORE_ROWS;

   localparam int SETTLE_CYCLES   = 30;
   localparam int TAIL_CYCLES     = 40;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int STALL_LIMIT     = 3000;
   localparam int PHASE_COUNT     = 14;
   localparam int PHASE_ITEMS     = 130;
   localparam int REPORT_LIMIT    = 10;

   // kernel weights scaled by 10000, row-major over the 3x3 window
   localparam int KERNEL_WEIGHTS [4][9] = '{
      '{-10000, -10000, -10000, -10000, 80000, -10000, -10000, -10000, -10000},
      '{0, -10000, 0, -10000, 50000, -10000, 0, -10000, 0},
      '{1111, 1111, 1111, 1111, 1111, 1111, 1111, 1111, 1111},
      '{625, 1250, 625, 1250, 2500, 1250, 625, 1250, 625}
   };

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic             filtered;
   } rgb_result_type;

   typedef enum {STEP_CSR, STEP_REQ} step_kind_type;

   typedef struct {
      step_kind_type  kind;
      csr_index_type  idx;
      int unsigned    value;
      req_kind_type   op;
      int unsigned    row;
      int unsigned    col;
      logic [23:0]    rgb;
      bit             typed;
      rgb_result_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [IDX_W-1:0] csr_index;
   logic [CFG_W-1:0] csr_wdata;

   // typed expectation riding along with the request on the bus
   logic           typed_on;
   rgb_result_type typed_val;

   rcf_req_if req_bus ();
   rcf_rsp_if rsp_bus ();

   rgb_conv3x3_filter_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow image and register copy
   logic [23:0]     pix_mem [STORE_DEPTH];
   bit              loaded [STORE_DEPTH];
   int unsigned     loaded_addrs [$];
   filter_mode_type cfg_mode   = MODE_EDGE;
   int unsigned     cfg_width  = RST_IMAGE_W;
   int unsigned     cfg_height = RST_IMAGE_H;
   int unsigned     cfg_left   = RST_SEL_LEFT;
   int unsigned     cfg_top    = RST_SEL_TOP;
   int unsigned     cfg_right  = RST_SEL_RIGHT;
   int unsigned     cfg_bottom = RST_SEL_BOT;

   rgb_result_type pending_pixels [$];
   stim_row_type   directed_q [$];
   csr_index_type  reg_idx_q [$];
   int unsigned    reg_val_q [$];

   int mismatch_count = 0;
   int stuck_cycles   = 0;
   int items_sent     = 0;
   int burst_left     = 0;
   bit hold_off_req   = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned store_addr(int unsigned r, int unsigned c);
      return r * STORE_COLS + c;
   endfunction

   // interior pixel inside the selection window
   function automatic bit kernel_applies(int unsigned r, int unsigned c);
      return r != 0 && c != 0 && r + 1 < cfg_height && c + 1 < cfg_width &&
             r + 1 < STORE_ROWS && c + 1 < STORE_COLS &&
             r >= cfg_top && r < cfg_bottom && c >= cfg_left && c < cfg_right;
   endfunction

   // divide by 10000, round half up, clamp to a byte
   function automatic logic [PIX_W-1:0] round_clamp(int sum);
      int q;
      if (sum <= 0) return '0;
      q = (sum + 5000) / 10000;
      return (q > 255) ? 8'd255 : PIX_W'(q);
   endfunction

   function automatic rgb_result_type convolve_pixel(int unsigned r, int unsigned c);
      rgb_result_type res;
      logic [23:0]    p;
      int             acc_r, acc_g, acc_b, w;
      int unsigned    dr, dc;
      res = '0;
      if (r >= STORE_ROWS || c >= STORE_COLS) return res;
      p = pix_mem[store_addr(r, c)];
      if (!kernel_applies(r, c)) begin
         res.red   = p[23:16];
         res.green = p[15:8];
         res.blue  = p[7:0];
         return res;
      end
      acc_r = 0;
      acc_g = 0;
      acc_b = 0;
      for (dr = 0; dr < 3; dr++) begin
         for (dc = 0; dc < 3; dc++) begin
            p = pix_mem[store_addr(r + dr - 1, c + dc - 1)];
            w = KERNEL_WEIGHTS[cfg_mode][dr * 3 + dc];
            acc_r += w * int'(p[23:16]);
            acc_g += w * int'(p[15:8]);
            acc_b += w * int'(p[7:0]);
         end
      end
      res.red      = round_clamp(acc_r);
      res.green    = round_clamp(acc_g);
      res.blue     = round_clamp(acc_b);
      res.filtered = 1'b1;
      return res;
   endfunction

   // a read may only touch pixels already loaded since reset
   function automatic bit read_is_safe(int unsigned r, int unsigned c);
      if (!loaded[store_addr(r, c)]) return 1'b0;
      if (!kernel_applies(r, c)) return 1'b1;
      for (int dr = 0; dr < 3; dr++)
         for (int dc = 0; dc < 3; dc++)
            if (!loaded[store_addr(r + dr - 1, c + dc - 1)]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [PIX_W-1:0] rand_byte();
      case ($urandom_range(0, 5))
         0:       return 8'h00;
         1:       return 8'hff;
         default: return PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [23:0] rand_pixel();
      return {rand_byte(), rand_byte(), rand_byte()};
   endfunction

   // centre coordinate inside [lo, hi) when that range exists, mostly
   function automatic int unsigned centre_in(int unsigned lo, int unsigned hi);
      if (lo < hi && $urandom_range(0, 3) != 0) return $urandom_range(lo, hi - 1);
      return $urandom_range(1, STORE_ROWS - 2);
   endfunction

   // request sender, bursts with random gaps
   task automatic offer(req_kind_type op, int unsigned r, int unsigned c,
                        logic [23:0] rgb, bit typed, rgb_result_type want);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      if (op == REQ_WRITE && !loaded[store_addr(r, c)]) begin
         loaded[store_addr(r, c)] = 1'b1;
         loaded_addrs.push_back(store_addr(r, c));
      end
      @(negedge clock);
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= op;
      req_bus.row      <= COORD_W'(r);
      req_bus.col      <= COORD_W'(c);
      req_bus.red_in   <= rgb[23:16];
      req_bus.green_in <= rgb[15:8];
      req_bus.blue_in  <= rgb[7:0];
      typed_on         <= typed;
      typed_val        <= want;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   // stop sending and let every expected result drain
   task automatic quiesce();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write queued registers once the block is idle
   task automatic apply_regs();
      csr_index_type idx;
      int unsigned   val;
      quiesce();
      while (reg_idx_q.size() > 0) begin
         idx = reg_idx_q.pop_front();
         val = reg_val_q.pop_front();
         @(negedge clock);
         csr_we    <= 1'b1;
         csr_index <= idx;
         csr_wdata <= CFG_W'(val);
         @(posedge clock);
         case (idx)
            CSR_FILTER_MODE: cfg_mode   = filter_mode_type'(val[MODE_W-1:0]);
            CSR_IMAGE_W:     cfg_width  = val;
            CSR_IMAGE_H:     cfg_height = val;
            CSR_SEL_LEFT:    cfg_left   = val;
            CSR_SEL_TOP:     cfg_top    = val;
            CSR_SEL_RIGHT:   cfg_right  = val;
            CSR_SEL_BOT:     cfg_bottom = val;
            default: ;
         endcase
      end
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic void dir_csr(csr_index_type idx, int unsigned val);
      stim_row_type s;
      s = '{kind: STEP_CSR, idx: idx, value: val, op: REQ_WRITE, row: 0, col: 0,
            rgb: '0, typed: 1'b0, want: '0};
      directed_q.push_back(s);
   endfunction

   function automatic void dir_req(req_kind_type op, int unsigned r, int unsigned c,
                                   logic [23:0] rgb, bit typed, rgb_result_type want);
      stim_row_type s;
      s = '{kind: STEP_REQ, idx: CSR_FILTER_MODE, value: 0, op: op, row: r, col: c,
            rgb: rgb, typed: typed, want: want};
      directed_q.push_back(s);
   endfunction

   // directed part: corners, every kernel on one patch, selection and border cases
   task automatic run_directed();
      dir_req(REQ_WRITE, 0, 0, 24'hffffff, 1'b0, '0);
      dir_req(REQ_READ, 0, 0, 24'h000000, 1'b1, '{8'hff, 8'hff, 8'hff, 1'b0});
      dir_req(REQ_WRITE, 511, 511, 24'h000000, 1'b0, '0);
      dir_req(REQ_READ, 511, 511, 24'hffffff, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b0});
      dir_req(REQ_WRITE, 0, 511, 24'hff00ff, 1'b0, '0);
      dir_req(REQ_READ, 0, 511, 24'h5a5a5a, 1'b1, '{8'hff, 8'h00, 8'hff, 1'b0});
      // patch around (2,2): bright red centre, blue neighbours
      for (int r = 1; r <= 3; r++)
         for (int c = 1; c <= 3; c++)
            dir_req(REQ_WRITE, r, c, (r == 2 && c == 2) ? 24'hff0a00 : 24'h0000ff,
                    1'b0, '0);
      dir_req(REQ_READ, 2, 2, 24'h0, 1'b1, '{8'hff, 8'h50, 8'h00, 1'b1});
      dir_csr(CSR_FILTER_MODE, MODE_SHARPEN);
      dir_req(REQ_READ, 2, 2, 24'h0, 1'b1, '{8'hff, 8'h32, 8'h00, 1'b1});
      dir_csr(CSR_FILTER_MODE, MODE_BOX);
      dir_req(REQ_READ, 2, 2, 24'h0, 1'b0, '0);
      dir_csr(CSR_FILTER_MODE, MODE_GAUSS);
      dir_req(REQ_READ, 2, 2, 24'h0, 1'b0, '0);
      // outside the selection window, then on the right image border
      dir_csr(CSR_SEL_LEFT, 3);
      dir_req(REQ_READ, 2, 2, 24'h0, 1'b1, '{8'hff, 8'h0a, 8'h00, 1'b0});
      dir_csr(CSR_SEL_LEFT, 0);
      dir_csr(CSR_IMAGE_W, 3);
      dir_req(REQ_READ, 2, 2, 24'h0, 1'b1, '{8'hff, 8'h0a, 8'h00, 1'b0});
      dir_csr(CSR_IMAGE_W, 512);

      foreach (directed_q[i]) begin
         if (directed_q[i].kind == STEP_CSR) begin
            reg_idx_q.push_back(directed_q[i].idx);
            reg_val_q.push_back(directed_q[i].value);
            apply_regs();
         end else begin
            offer(directed_q[i].op, directed_q[i].row, directed_q[i].col,
                  directed_q[i].rgb, directed_q[i].typed, directed_q[i].want);
         end
      end
   endtask

   // one random phase: new register setting, then patches, reads and noise
   task automatic run_phase(int p);
      int unsigned lf, tp, rt, bt, w, h, r, c, rr, cc, a, lo_r, hi_r, lo_c, hi_c;
      int          start, nreads;
      bit          paused;
      case (p % 5)
         0: begin
            w = 512; h = 512; lf = 0; tp = 0; rt = 512; bt = 512;
         end
         1: begin
            w = $urandom_range(1, 3); h = $urandom_range(1, 3);
            lf = 512; tp = 512; rt = 0; bt = 0;
         end
         default: begin
            w  = $urandom_range(3, 512);
            h  = $urandom_range(3, 512);
            lf = $urandom_range(0, 100);
            tp = $urandom_range(0, 100);
            rt = $urandom_range(lf, 512);
            bt = $urandom_range(tp, 512);
         end
      endcase
      reg_idx_q = '{CSR_FILTER_MODE, CSR_IMAGE_W, CSR_IMAGE_H, CSR_SEL_LEFT,
                    CSR_SEL_TOP, CSR_SEL_RIGHT, CSR_SEL_BOT};
      reg_val_q = '{p % 4, w, h, lf, tp, rt, bt};
      apply_regs();

      // receiver holds off while requests keep coming
      if (p % 7 == 3) hold_off_req = 1'b1;

      lo_r = (cfg_top > 1) ? cfg_top : 1;
      hi_r = (cfg_bottom < cfg_height - 1) ? cfg_bottom : cfg_height - 1;
      lo_c = (cfg_left > 1) ? cfg_left : 1;
      hi_c = (cfg_right < cfg_width - 1) ? cfg_right : cfg_width - 1;
      start  = items_sent;
      paused = 1'b0;
      while (items_sent - start < PHASE_ITEMS) begin
         if (p % 7 == 6 && !paused && items_sent - start > PHASE_ITEMS / 2) begin
            quiesce();
            paused = 1'b1;
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               // load a 3x3 patch, then read inside it
               r = centre_in(lo_r, hi_r);
               c = centre_in(lo_c, hi_c);
               for (int dr = 0; dr < 3; dr++)
                  for (int dc = 0; dc < 3; dc++)
                     offer(REQ_WRITE, r + dr - 1, c + dc - 1, rand_pixel(), 1'b0, '0);
               nreads = $urandom_range(1, 3);
               repeat (nreads) begin
                  rr = r + $urandom_range(0, 2) - 1;
                  cc = c + $urandom_range(0, 2) - 1;
                  if (!read_is_safe(rr, cc)) begin
                     rr = r;
                     cc = c;
                  end
                  offer(REQ_READ, rr, cc, rand_pixel(), 1'b0, '0);
               end
            end
            6, 7: begin
               offer(REQ_WRITE, $urandom_range(0, STORE_ROWS - 1),
                     $urandom_range(0, STORE_COLS - 1), rand_pixel(), 1'b0, '0);
            end
            default: begin
               // revisit some loaded pixel; reload it if a neighbour is missing
               a  = loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)];
               rr = a / STORE_COLS;
               cc = a % STORE_COLS;
               offer(read_is_safe(rr, cc) ? REQ_READ : REQ_WRITE, rr, cc, rand_pixel(),
                     1'b0, '0);
            end
         endcase
      end
   endtask

   // prediction on accepted requests, checking on accepted results
   always @(posedge clock) begin : scoreboard
      rgb_result_type want, got;
      if (req_bus.valid && req_bus.ready) begin
         if (req_bus.req_type == REQ_WRITE)
            pix_mem[store_addr(req_bus.row, req_bus.col)] =
               {req_bus.red_in, req_bus.green_in, req_bus.blue_in};
         else
            pending_pixels.push_back(typed_on ? typed_val
                                              : convolve_pixel(req_bus.row, req_bus.col));
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.red_out, rsp_bus.green_out, rsp_bus.blue_out, rsp_bus.filtered};
         if (pending_pixels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("tb: unexpected result at %0t: r=%h g=%h b=%h f=%b", $realtime,
                        got.red, got.green, got.blue, got.filtered);
         end else begin
            want = pending_pixels.pop_front();
            if (got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue || got.filtered !== want.filtered) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("tb: mismatch at %0t: want r=%h g=%h b=%h f=%b, got r=%h g=%h b=%h f=%b",
                           $realtime, want.red, want.green, want.blue, want.filtered,
                           got.red, got.green, got.blue, got.filtered);
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || csr_we)
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // result receiver: a random stall pattern that is redrawn on a tick counter, plus a long hold-off
   initial begin : rsp_receiver
      int unsigned tick;
      logic [15:0] pattern;
      tick    = 0;
      pattern = '0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_req = 1'b0;
         end else begin
            if (tick % 64 == 0) begin
               case ($urandom_range(0, 3))
                  0:       pattern = '0;
                  1:       pattern = 16'($urandom) & 16'($urandom);
                  default: pattern = 16'($urandom);
               endcase
            end
            rsp_bus.ready <= !pattern[tick % 16];
            tick++;
         end
      end
   end

   // main sequence
   initial begin
      reset            <= 1'b1;
      csr_we           <= 1'b0;
      csr_index        <= CSR_FILTER_MODE;
      csr_wdata        <= '0;
      typed_on         <= 1'b0;
      typed_val        <= '0;
      req_bus.valid    <= 1'b0;
      req_bus.req_type <= REQ_WRITE;
      req_bus.row      <= '0;
      req_bus.col      <= '0;
      req_bus.red_in   <= '0;
      req_bus.green_in <= '0;
      req_bus.blue_in  <= '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();
      for (int p = 0; p < PHASE_COUNT; p++)
         run_phase(p);

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_pixels.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
